// ===== rtl/great_circle_distance_assert.svh =====
// Assertion macros shared by the great-circle distance RTL.
// Used by gcd_pipe_ctl and the top level; no other dependencies.
`ifndef GREAT_CIRCLE_DISTANCE_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_ASSERT_SVH
// Property a implies b on the next edge, outside reset.
`define GCD_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("gcd: check failed");
// Property a implies b in the same cycle, outside reset.
`define GCD_ASSERT_NOW(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("gcd: check failed");
`endif

// ===== rtl/gcd_pkg.sv =====
// Types, constants and helper functions for the great-circle distance block.
// No dependencies.
`default_nettype none
package gcd_pkg;
    localparam int QW = 36;
    localparam logic signed [QW-1:0] Q_ONE = 36'sd1073741824;
    localparam logic signed [QW-1:0] CORDIC_GAIN = 36'sd652032874;
    localparam logic [24:0] DIST_MAX = 25'd22000000;
    localparam logic [31:0] RAD_MUL = 32'd2398762259;
    localparam logic [26:0] TURN = 27'd47185920;
    localparam logic [1:0] REG_RADIUS = 2'd0;

    typedef logic signed [QW-1:0] q_t;

    function automatic q_t atan_step(input int i);
        q_t r;
        r = '0;
        unique case (i)
            0: r = 36'sd843314856;
            1: r = 36'sd497837829;
            2: r = 36'sd263043836;
            3: r = 36'sd133525158;
            4: r = 36'sd67021686;
            5: r = 36'sd33543515;
            6: r = 36'sd16775850;
            7: r = 36'sd8388437;
            8: r = 36'sd4194282;
            9: r = 36'sd2097149;
            default: r = (i <= 30) ? (q_t'(1) <<< (30 - i)) : '0;
        endcase
        return r;
    endfunction

    function automatic q_t clampq(input q_t v, input q_t lo, input q_t hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction
endpackage
`default_nettype wire

// ===== rtl/gcd_cordic_cell.sv =====
// One CORDIC micro-rotation cell, rotation or vectoring mode, registered.
// Uses gcd_pkg.
`default_nettype none
module gcd_cordic_cell #(
    parameter int IDX = 0,
    parameter bit VECT = 1'b0
) (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire gcd_pkg::q_t x_in,
    input  wire gcd_pkg::q_t y_in,
    input  wire gcd_pkg::q_t z_in,
    output gcd_pkg::q_t      x_out,
    output gcd_pkg::q_t      y_out,
    output gcd_pkg::q_t      z_out
);
    gcd_pkg::q_t x_reg, y_reg, z_reg, x_next, y_next, z_next;
    gcd_pkg::q_t dx, dy, at;
    logic pos;

    always_comb begin
        dx = x_in; dy = y_in;
        dx = y_in >>> IDX;
        dy = x_in >>> IDX;
        at = gcd_pkg::atan_step(IDX);
        pos = VECT ? (y_in <= 0) : (z_in >= 0);
        if (VECT ? (y_in > 0) : pos) begin
            x_next = VECT ? x_in + dx : x_in - dx;
            y_next = VECT ? y_in - dy : y_in + dy;
            z_next = VECT ? z_in + at : z_in - at;
        end else begin
            x_next = VECT ? x_in - dx : x_in + dx;
            y_next = VECT ? y_in + dy : y_in - dy;
            z_next = VECT ? z_in - at : z_in + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule
`default_nettype wire

// ===== rtl/gcd_sqrt_cell.sv =====
// One step of the two-bits-a-step integer square root, registered.
// Uses no package items beyond plain logic.
`default_nettype none
module gcd_sqrt_cell #(
    parameter int STEP = 0
) (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [61:0] n_in,
    input  wire logic [31:0] r_in,
    output logic      [61:0] n_out,
    output logic      [31:0] r_out
);
    localparam int SH = 62 - 2 * STEP;
    logic [63:0] trial, nn;
    logic [61:0] n_reg, n_next;
    logic [31:0] r_reg, r_next;

    always_comb begin
        // trial is (4r+1) at this step's digit weight
        trial = ({32'd0, r_in} << (SH + 2)) + (64'd1 << SH);
        nn = {2'd0, n_in};
        if (nn >= trial) begin
            n_next = 62'(nn - trial);
            r_next = {r_in[30:0], 1'b1};
        end else begin
            n_next = n_in;
            r_next = {r_in[30:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg <= n_next;
            r_reg <= r_next;
        end
    end

    assign n_out = n_reg;
    assign r_out = r_reg;
endmodule
`default_nettype wire

// ===== rtl/gcd_pipe_ctl.sv =====
// Valid tracking and stall control for the pipeline.
// Uses great_circle_distance_assert.svh.
`default_nettype none
`include "great_circle_distance_assert.svh"
module gcd_pipe_ctl #(
    parameter int DEPTH = 70
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      en,
    output logic      last_valid,
    input  wire logic out_ready,
    output logic      out_valid
);
    logic [DEPTH-1:0] v_reg, v_next;

    assign out_valid = v_reg[DEPTH-1];
    assign en = !out_valid || out_ready;
    assign in_ready = en;
    assign last_valid = v_reg[DEPTH-1];

    always_comb begin
        v_next = v_reg;
        if (en) v_next = {v_reg[DEPTH-2:0], in_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v_reg <= '0;
        else v_reg <= v_next;
    end

    `GCD_ASSERT_NEXT(a_hold, aclk, aresetn, out_valid && !out_ready, out_valid)
    `GCD_ASSERT_NEXT(a_shift, aclk, aresetn, in_valid && in_ready, v_reg[0])
    `GCD_ASSERT_NOW(a_en, aclk, aresetn, !out_valid, in_ready)
endmodule
`default_nettype wire

// ===== rtl/great_circle_distance.sv =====
// Great-circle distance top level: angle reduction, CORDIC sin/cos, square
// roots, vectoring CORDIC and scaling. Uses gcd_pkg and the gcd_* cells.
// A new point pair is accepted every cycle while the output is not stalled;
// the pipeline holds the two angle reduction stages, the sin/cos cell row,
// four product stages, the 32-cell square root row and its rounding stage,
// the atan2 cell row and three radius scaling stages. A result that is not
// taken stalls the whole row, and the input with it.
`default_nettype none
`include "great_circle_distance_assert.svh"
module great_circle_distance #(
    parameter int CORDIC_STAGES = 30
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // first_longitude[24:0], first_latitude[48:25], second_longitude[73:49],
    // second_latitude[97:74]
    input  wire logic [103:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // distance_m[24:0]
    output logic [31:0]       m_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [1:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam int S = CORDIC_STAGES;
    localparam int DEPTH = 2 * S + 42;
    localparam logic signed [28:0] TURN_S = 29'(gcd_pkg::TURN);
    localparam logic signed [28:0] HALF_S = 29'(gcd_pkg::TURN / 2);
    localparam logic signed [28:0] QUART_S = 29'(gcd_pkg::TURN / 4);
    typedef gcd_pkg::q_t q_t;

    logic [22:0] radius_reg;
    logic en, lv;

    assign pready = 1'b1;
    assign prdata = (paddr == gcd_pkg::REG_RADIUS) ? {9'd0, radius_reg} : 32'd0;
    always_ff @(posedge aclk) begin
        if (!aresetn) radius_reg <= 23'd6371000;
        else if (psel && penable && pwrite && paddr == gcd_pkg::REG_RADIUS)
            radius_reg <= pwdata[22:0];
    end

    gcd_pipe_ctl #(.DEPTH(DEPTH)) u_ctl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .en(en), .last_valid(lv), .out_ready(m_tready), .out_valid(m_tvalid)
    );

    // four angles in 2^-17 degree: reduce and fold, then scale to radians
    logic signed [26:0] ang [4];
    logic signed [24:0] lon1, lon2;
    logic signed [23:0] lat1, lat2;
    assign lon1 = s_tdata[24:0];
    assign lat1 = s_tdata[48:25];
    assign lon2 = s_tdata[73:49];
    assign lat2 = s_tdata[97:74];
    assign ang[0] = 27'(lat1) - 27'(lat2);
    assign ang[1] = 27'(lon1) - 27'(lon2);
    assign ang[2] = 27'(lat1) <<< 1;
    assign ang[3] = 27'(lat2) <<< 1;

    q_t z0_reg [4];
    logic [S+1:0] flip_reg [4];
    q_t cx [4][S+1], cy [4][S+1], cz [4][S+1];

    for (genvar k = 0; k < 4; k++) begin : g_ang
        logic signed [28:0] r;
        logic f;
        logic [27:0] m, m_reg;
        logic neg_reg;
        logic [59:0] p;
        q_t zn;
        always_comb begin
            // ang stays within one turn either side of zero
            r = 29'(ang[k]);
            if (r < 0) r = r + TURN_S;
            if (r >= HALF_S) r = r - TURN_S;
            f = 1'b0;
            if (r > QUART_S) begin
                r = HALF_S - r; f = 1'b1;
            end else if (r < -QUART_S) begin
                r = -HALF_S - r; f = 1'b1;
            end
            m = (r < 0) ? 28'(-r) : 28'(r);
        end
        always_comb begin
            p = (60'(m_reg) * 60'(gcd_pkg::RAD_MUL) + (60'd1 << 23)) >> 24;
            zn = neg_reg ? -q_t'(p) : q_t'(p);
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                m_reg <= m;
                neg_reg <= (r < 0);
                z0_reg[k] <= zn;
                flip_reg[k] <= {flip_reg[k][S:0], f};
            end
        end
        assign cx[k][0] = gcd_pkg::CORDIC_GAIN;
        assign cy[k][0] = '0;
        assign cz[k][0] = z0_reg[k];
        for (genvar i = 0; i < S; i++) begin : g_c
            gcd_cordic_cell #(.IDX(i), .VECT(1'b0)) u_c (
                .aclk(aclk), .en(en), .x_in(cx[k][i]), .y_in(cy[k][i]),
                .z_in(cz[k][i]), .x_out(cx[k][i+1]), .y_out(cy[k][i+1]),
                .z_out(cz[k][i+1])
            );
        end
    end

    // products: stage A sin/cos clamp, B squares and cos product, C cos product times sin^2, D a
    q_t slat_reg, slon_reg, c1_reg, c2_reg;
    q_t ss_reg, sl_reg, cc_reg, ss2_reg, css_reg, a_reg;
    function automatic q_t mulq(input q_t a, input q_t b);
        logic signed [71:0] p;
        p = (72'(a) * 72'(b) + (72'sd1 <<< 29)) >>> 30;
        return q_t'(p);
    endfunction
    always_ff @(posedge aclk) begin
        if (en) begin
            slat_reg <= gcd_pkg::clampq(cy[0][S], -gcd_pkg::Q_ONE, gcd_pkg::Q_ONE);
            slon_reg <= gcd_pkg::clampq(cy[1][S], -gcd_pkg::Q_ONE, gcd_pkg::Q_ONE);
            c1_reg <= flip_reg[2][S+1] ?
                -gcd_pkg::clampq(cx[2][S], -gcd_pkg::Q_ONE, gcd_pkg::Q_ONE) :
                gcd_pkg::clampq(cx[2][S], -gcd_pkg::Q_ONE, gcd_pkg::Q_ONE);
            c2_reg <= flip_reg[3][S+1] ?
                -gcd_pkg::clampq(cx[3][S], -gcd_pkg::Q_ONE, gcd_pkg::Q_ONE) :
                gcd_pkg::clampq(cx[3][S], -gcd_pkg::Q_ONE, gcd_pkg::Q_ONE);
            ss_reg <= mulq(slat_reg, slat_reg);
            sl_reg <= mulq(slon_reg, slon_reg);
            cc_reg <= mulq(c1_reg, c2_reg);
            ss2_reg <= ss_reg;
            css_reg <= mulq(cc_reg, sl_reg);
            a_reg <= gcd_pkg::clampq(ss2_reg + css_reg, '0, gcd_pkg::Q_ONE);
        end
    end

    // square roots of 1-a and a
    logic [61:0] sn [2][33];
    logic [31:0] sr [2][33];
    assign sn[0][0] = 62'(gcd_pkg::Q_ONE - a_reg) << 30;
    assign sn[1][0] = 62'(a_reg) << 30;
    assign sr[0][0] = '0;
    assign sr[1][0] = '0;
    for (genvar k = 0; k < 2; k++) begin : g_sq
        for (genvar i = 0; i < 32; i++) begin : g_s
            gcd_sqrt_cell #(.STEP(i)) u_s (
                .aclk(aclk), .en(en), .n_in(sn[k][i]), .r_in(sr[k][i]),
                .n_out(sn[k][i+1]), .r_out(sr[k][i+1])
            );
        end
    end
    q_t rx_reg, ry_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            rx_reg <= q_t'(sr[0][32]) + q_t'(sn[0][32] > 62'(sr[0][32]));
            ry_reg <= q_t'(sr[1][32]) + q_t'(sn[1][32] > 62'(sr[1][32]));
        end
    end

    // atan2 cell row
    q_t vx [S+1], vy [S+1], vz [S+1];
    assign vx[0] = rx_reg;
    assign vy[0] = ry_reg;
    assign vz[0] = '0;
    for (genvar i = 0; i < S; i++) begin : g_v
        gcd_cordic_cell #(.IDX(i), .VECT(1'b1)) u_v (
            .aclk(aclk), .en(en), .x_in(vx[i]), .y_in(vy[i]), .z_in(vz[i]),
            .x_out(vx[i+1]), .y_out(vy[i+1]), .z_out(vz[i+1])
        );
    end

    // scale by radius, round, saturate
    logic [32:0] c_reg;
    logic [56:0] d_reg;
    logic [24:0] dist_reg;
    logic [26:0] dsh;
    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg <= (vz[S] < 0) ? '0 : 33'(vz[S] <<< 1);
            d_reg <= 57'(radius_reg) * 57'(c_reg) + (57'd1 << 29);
            dist_reg <= (dsh > 27'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX : dsh[24:0];
        end
    end
    assign dsh = d_reg[56:30];
    assign m_tdata = {7'd0, dist_reg};

    `GCD_ASSERT_NOW(a_sat, aclk, aresetn, m_tvalid, dist_reg <= gcd_pkg::DIST_MAX)
    `GCD_ASSERT_NOW(a_rdy, aclk, aresetn, m_tvalid && !m_tready, !s_tready)
    `GCD_ASSERT_NOW(a_lv, aclk, aresetn, lv, m_tvalid)
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for the haversine great-circle distance block.
// Drives random and corner point pairs over the stream port, predicts each
// distance in SV and compares; needs gcd_pkg and great_circle_distance.
`default_nettype none
module tb_top;
    typedef struct packed {
        logic signed [23:0] lat2;
        logic signed [24:0] lon2;
        logic signed [23:0] lat1;
        logic signed [24:0] lon1;
    } pair_t;

    localparam logic signed [24:0] LON_MAX = 25'sd11796480;
    localparam logic signed [23:0] LAT_MAX = 24'sd5898240;
    localparam longint TURN_L = 47185920;
    localparam longint QONE_L = 64'sd1073741824;
    localparam int LATENCY = 2 * 30 + 42;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [1:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    great_circle_distance u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    pair_t       pending_pairs[$];
    logic [24:0] expected_dist[$];
    longint      radius_m = 6371000;
    int          errors = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_radii = 0;
    int          sender_gap = 0;
    int          receiver_gap = 0;
    int          hold_off = 0;
    bit          hold_input = 1'b0;

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint cordic_angle(int i);
        return longint'(gcd_pkg::atan_step(i));
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint mul_q30(longint a, longint b);
        return asr(a * b + (64'sd1 <<< 29), 30);
    endfunction

    // angle in 2^-17 degree -> {sin, cos} in Q2.30
    function automatic void rotate(longint ang, output longint s, output longint c);
        longint r, m, z, x, y, dx, dy, t;
        bit flip;
        flip = 1'b0;
        r = ang % TURN_L;
        if (r < 0) r += TURN_L;
        if (r >= TURN_L / 2) r -= TURN_L;
        if (r > TURN_L / 4) begin
            r = TURN_L / 2 - r;
            flip = 1'b1;
        end else if (r < -TURN_L / 4) begin
            r = -TURN_L / 2 - r;
            flip = 1'b1;
        end
        m = r < 0 ? -r : r;
        z = (m * 64'sd2398762259 + (64'sd1 <<< 23)) >>> 24;
        if (r < 0) z = -z;
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            dx = asr(y, i);
            dy = asr(x, i);
            t = cordic_angle(i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= t;
            end else begin
                x += dx; y -= dy; z += t;
            end
        end
        s = clampl(y, -QONE_L, QONE_L);
        c = clampl(x, -QONE_L, QONE_L);
        if (flip) c = -c;
    endfunction

    function automatic longint root_q30(longint v);
        logic [63:0] n, res, bit_w;
        n = 64'(v) << 30;
        res = '0;
        bit_w = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (n >= res + bit_w) begin
                n -= res + bit_w;
                res = (res >> 1) + bit_w;
            end else begin
                res >>= 1;
            end
            bit_w >>= 2;
        end
        if (n > res) res++;
        return longint'(res);
    endfunction

    function automatic logic [24:0] distance_of(pair_t p, longint rad);
        longint slat, slon, c1, c2, t, a, x, y, z, dx, dy;
        logic [63:0] d;
        rotate(longint'(p.lat1) - longint'(p.lat2), slat, t);
        rotate(longint'(p.lon1) - longint'(p.lon2), slon, t);
        rotate(2 * longint'(p.lat1), t, c1);
        rotate(2 * longint'(p.lat2), t, c2);
        a = mul_q30(slat, slat) + mul_q30(mul_q30(c1, c2), mul_q30(slon, slon));
        a = clampl(a, 0, QONE_L);
        x = root_q30(QONE_L - a);
        y = root_q30(a);
        z = 0;
        for (int i = 0; i < 30; i++) begin
            dx = asr(y, i);
            dy = asr(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += cordic_angle(i);
            end else begin
                x -= dx; y += dy; z -= cordic_angle(i);
            end
        end
        z = 2 * z;
        if (z < 0) z = 0;
        d = (64'(rad) * 64'(z) + (64'd1 << 29)) >> 30;
        if (d > 64'(gcd_pkg::DIST_MAX)) d = 64'(gcd_pkg::DIST_MAX);
        return d[24:0];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver
    always @(posedge aclk) begin
        int gap;
        if (aresetn) begin
            gap = sender_gap;
            if (s_tvalid && s_tready) begin
                expected_dist.push_back(distance_of(pair_t'(s_tdata[97:0]), radius_m));
                n_sent++;
                gap = pick_gap();
            end
            if (!s_tvalid || s_tready) begin
                if (gap > 0) begin
                    gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_pairs.size() > 0 && !hold_input) begin
                    s_tdata <= {6'd0, pending_pairs.pop_front()};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            sender_gap <= gap;
        end
    end

    // monitor
    always @(posedge aclk) begin
        logic [24:0] want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_dist.size() == 0) begin
                    $error("unexpected result distance_m=%0d", m_tdata[24:0]);
                    errors++;
                end else begin
                    want = expected_dist.pop_front();
                    if (m_tdata[24:0] !== want) begin
                        $error("distance_m expected %0d actual %0d", want, m_tdata[24:0]);
                        errors++;
                    end
                    n_checked++;
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_tready <= 1'b0;
            end else if (receiver_gap > 0) begin
                receiver_gap <= receiver_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                receiver_gap <= pick_gap();
            end
        end
    end

    function automatic pair_t random_pair();
        pair_t p;
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            p.lon1 = 25'($signed($urandom_range(0, 2 * 11796480)) - LON_MAX);
            p.lat1 = 24'($signed($urandom_range(0, 2 * 5898240)) - LAT_MAX);
            if (r < 3) begin
                p.lon2 = 25'(p.lon1 + $signed($urandom_range(0, 2000000)) - 25'sd1000000);
                p.lat2 = 24'(p.lat1 + $signed($urandom_range(0, 200000)) - 24'sd100000);
            end else begin
                p.lon2 = 25'($signed($urandom_range(0, 2 * 11796480)) - LON_MAX);
                p.lat2 = 24'($signed($urandom_range(0, 2 * 5898240)) - LAT_MAX);
            end
        end else begin
            p = pair_t'(98'({$urandom, $urandom, $urandom, $urandom}));
        end
        return p;
    endfunction

    task automatic set_radius(longint rad);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= gcd_pkg::REG_RADIUS; pwdata <= 32'(rad);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        radius_m = rad & 64'h7FFFFF;
        n_radii++;
    endtask

    task automatic drain();
        wait (pending_pairs.size() == 0 && !s_tvalid && expected_dist.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic queue_pair(logic signed [24:0] a, logic signed [23:0] b,
                              logic signed [24:0] c, logic signed [23:0] d);
        pair_t p;
        p.lon1 = a; p.lat1 = b; p.lon2 = c; p.lat2 = d;
        pending_pairs.push_back(p);
    endtask

    initial begin
        longint radii[5];
        radii = '{6371000, 6000000, 7000000, 0, 8388607};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        // corners: same point, antipodes, poles, range limits, raw field extremes
        queue_pair(0, 0, 0, 0);
        queue_pair(LON_MAX, LAT_MAX, LON_MAX, LAT_MAX);
        queue_pair(0, 0, LON_MAX, 0);
        queue_pair(-LON_MAX, 0, LON_MAX, 0);
        queue_pair(0, LAT_MAX, 0, -LAT_MAX);
        queue_pair(0, 0, LON_MAX, LAT_MAX);
        queue_pair(-LON_MAX, -LAT_MAX, LON_MAX, LAT_MAX);
        queue_pair(25'sh0FFFFFF, 24'sh7FFFFF, -25'sh1000000, -24'sh800000);
        queue_pair(-25'sh1000000, -24'sh800000, 25'sh0FFFFFF, 24'sh7FFFFF);
        queue_pair(0, 0, 1, 0);
        queue_pair(0, 0, 0, 1);
        queue_pair(100, 200, 100, 201);
        queue_pair(0, 24'sd3000000, 25'sd11796479, -24'sd3000000);
        drain();
        for (int ph = 0; ph < 5; ph++) begin
            set_radius(radii[ph]);
            for (int k = 0; k < 320; k++) pending_pairs.push_back(random_pair());
            if (ph == 1) begin
                // long receiver stall while items keep coming
                @(posedge aclk);
                hold_off <= 400;
            end
            if (ph == 2) begin
                wait (pending_pairs.size() < 160);
                hold_input = 1'b1;
                wait (expected_dist.size() == 0 && !s_tvalid);
                hold_input = 0;
            end
            drain();
        end
        $display("covered %0d point pairs, %0d checked, over %0d radius settings",
                 n_sent, n_checked, n_radii);
        if (errors == 0 && expected_dist.size() == 0)
            $display("** great_circle_distance: PASSED **");
        else
            $display("** great_circle_distance: FAILED **");
        $finish;
    end

    initial begin
        #10000000;
        $display("** great_circle_distance: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
